// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the extractor core RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SHTP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SHTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/shtp_pkg.sv -----
`default_nettype none
package shtp_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int LEN_W = 15;
	localparam int TOTAL_W = 32;

	localparam logic [LEN_W-1:0] HDR_LEN = 15'd4;
	localparam logic [LEN_W-1:0] LEN_ACCEL = 15'd10;
	localparam logic [LEN_W-1:0] LEN_TIMEBASE = 15'd5;
	localparam logic [LEN_W-1:0] MAX_LEN_RST = 15'd512;
	localparam logic [7:0] REPORT_CHAN_RST = 8'd3;
	localparam logic [15:0] NO_PACKET = 16'hFFFF;
	localparam logic [7:0] ID_ACCEL = 8'h01;
	localparam logic [7:0] ID_TIMEBASE = 8'hFB;

	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic REG_REPORT_CHAN = 1'b1;

	typedef enum logic [1:0] {
		EVT_SAMPLE = 2'd0,
		EVT_READ_ERR = 2'd1,
		EVT_PARSE_ERR = 2'd2
	} evt_kind_t;

	typedef enum logic [4:0] {
		HDR_IDLE = 5'b00001,
		HDR_LEN_HI = 5'b00010,
		HDR_CHAN = 5'b00100,
		HDR_SEQ = 5'b01000,
		HDR_PAYLOAD = 5'b10000
	} hdr_state_t;

	typedef enum logic [3:0] {
		REC_ID = 4'b0001,
		REC_ACCEL = 4'b0010,
		REC_TIMEBASE = 4'b0100,
		REC_DISCARD = 4'b1000
	} rec_state_t;

	typedef struct packed {
		logic [LEN_W-1:0] max_len;
		logic [7:0] report_chan;
	} cfg_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] parse_error_total;
		logic [TOTAL_W-1:0] read_error_total;
		logic [TOTAL_W-1:0] sample_total;
		logic signed [15:0] accel_z;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_x;
		logic [1:0] accuracy;
	} evt_data_t;

	typedef struct packed {
		logic valid;
		evt_kind_t kind;
		evt_data_t data;
	} evt_t;

endpackage
`default_nettype wire

// ----- rtl/shtp_regs.sv -----
`default_nettype none
module shtp_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output shtp_pkg::cfg_t cfg
);

	shtp_pkg::cfg_t cfg_q;
	logic wr_en;
	logic reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len <= shtp_pkg::MAX_LEN_RST;
			cfg_q.report_chan <= shtp_pkg::REPORT_CHAN_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				shtp_pkg::REG_MAX_LEN: cfg_q.max_len <= pwdata[shtp_pkg::LEN_W-1:0];
				shtp_pkg::REG_REPORT_CHAN: cfg_q.report_chan <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			shtp_pkg::REG_MAX_LEN: prdata = 32'(cfg_q.max_len);
			shtp_pkg::REG_REPORT_CHAN: prdata = 32'(cfg_q.report_chan);
			default: prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/shtp_parse.sv -----
`default_nettype none
module shtp_parse #(
	parameter int COUNT_BITS = shtp_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic [7:0] in_byte,
	input wire logic in_start,
	input wire shtp_pkg::cfg_t cfg,
	output shtp_pkg::evt_t evt
);

	localparam int EXT_W = (COUNT_BITS > shtp_pkg::TOTAL_W) ? COUNT_BITS : shtp_pkg::TOTAL_W;
	localparam logic [3:0] OFF_STATUS = 4'd2;
	localparam logic [3:0] OFF_X_LO = 4'd4;
	localparam logic [3:0] OFF_X_HI = 4'd5;
	localparam logic [3:0] OFF_Y_LO = 4'd6;
	localparam logic [3:0] OFF_Y_HI = 4'd7;
	localparam logic [3:0] OFF_Z_LO = 4'd8;
	localparam logic [3:0] ACCEL_LAST = 4'(shtp_pkg::LEN_ACCEL - 15'd1);
	localparam logic [3:0] TB_LAST = 4'(shtp_pkg::LEN_TIMEBASE - 15'd1);

	shtp_pkg::hdr_state_t hdr_q, hdr_d;
	shtp_pkg::rec_state_t rec_q, rec_d;
	logic [3:0] off_q, off_d;
	logic [7:0] len_lo_q, len_lo_d;
	logic [7:0] chan_q, chan_d;
	logic [shtp_pkg::LEN_W-1:0] rem_q, rem_d;
	logic [1:0] status_q, status_d;
	logic [15:0] x_q, x_d;
	logic [15:0] y_q, y_d;
	logic [7:0] zlo_q, zlo_d;
	logic [COUNT_BITS-1:0] samp_q, samp_d;
	logic [COUNT_BITS-1:0] rderr_q, rderr_d;
	logic [COUNT_BITS-1:0] perr_q, perr_d;

	logic [15:0] raw_len;
	logic [shtp_pkg::LEN_W-1:0] pkt_len;
	logic [shtp_pkg::LEN_W-1:0] need_len;
	logic is_accel_id;
	logic is_tb_id;
	logic [EXT_W-1:0] samp_ext;
	logic [EXT_W-1:0] rderr_ext;
	logic [EXT_W-1:0] perr_ext;

	assign raw_len = {in_byte, len_lo_q};
	assign pkt_len = raw_len[shtp_pkg::LEN_W-1:0];
	assign is_accel_id = (in_byte == shtp_pkg::ID_ACCEL);
	assign is_tb_id = (in_byte == shtp_pkg::ID_TIMEBASE);
	assign need_len = is_accel_id ? shtp_pkg::LEN_ACCEL : shtp_pkg::LEN_TIMEBASE;

	assign samp_ext = EXT_W'(samp_d);
	assign rderr_ext = EXT_W'(rderr_d);
	assign perr_ext = EXT_W'(perr_d);

	always_comb begin
		hdr_d = hdr_q;
		rec_d = rec_q;
		off_d = off_q;
		len_lo_d = len_lo_q;
		chan_d = chan_q;
		rem_d = rem_q;
		status_d = status_q;
		x_d = x_q;
		y_d = y_q;
		zlo_d = zlo_q;
		samp_d = samp_q;
		rderr_d = rderr_q;
		perr_d = perr_q;
		evt.valid = 1'b0;
		evt.kind = shtp_pkg::EVT_SAMPLE;
		evt.data.accuracy = '0;
		evt.data.accel_x = '0;
		evt.data.accel_y = '0;
		evt.data.accel_z = '0;
		if (in_start) begin
			len_lo_d = in_byte;
			rec_d = shtp_pkg::REC_ID;
			off_d = '0;
			rem_d = '0;
			hdr_d = shtp_pkg::HDR_LEN_HI;
		end else begin
			unique case (hdr_q)
				shtp_pkg::HDR_LEN_HI: begin
					if (raw_len == 16'd0 || raw_len == shtp_pkg::NO_PACKET) begin
						hdr_d = shtp_pkg::HDR_IDLE;
					end else if (pkt_len < shtp_pkg::HDR_LEN || pkt_len > cfg.max_len) begin
						rderr_d = rderr_q + COUNT_BITS'(1);
						evt.valid = 1'b1;
						evt.kind = shtp_pkg::EVT_READ_ERR;
						hdr_d = shtp_pkg::HDR_IDLE;
					end else begin
						rem_d = pkt_len - shtp_pkg::HDR_LEN;
						hdr_d = shtp_pkg::HDR_CHAN;
					end
				end
				shtp_pkg::HDR_CHAN: begin
					chan_d = in_byte;
					hdr_d = shtp_pkg::HDR_SEQ;
				end
				shtp_pkg::HDR_SEQ: begin
					rec_d = (chan_q == cfg.report_chan) ? shtp_pkg::REC_ID : shtp_pkg::REC_DISCARD;
					off_d = '0;
					hdr_d = (rem_q == '0) ? shtp_pkg::HDR_IDLE : shtp_pkg::HDR_PAYLOAD;
				end
				shtp_pkg::HDR_PAYLOAD: begin
					unique case (rec_q)
						shtp_pkg::REC_ID: begin
							if (is_accel_id || is_tb_id) begin
								if (rem_q < need_len) begin
									perr_d = perr_q + COUNT_BITS'(1);
									evt.valid = 1'b1;
									evt.kind = shtp_pkg::EVT_PARSE_ERR;
									rec_d = shtp_pkg::REC_DISCARD;
								end else begin
									rec_d = is_accel_id ? shtp_pkg::REC_ACCEL
										: shtp_pkg::REC_TIMEBASE;
									off_d = 4'd1;
								end
							end
						end
						shtp_pkg::REC_ACCEL: begin
							unique case (off_q)
								OFF_STATUS: status_d = in_byte[1:0];
								OFF_X_LO: x_d = {x_q[15:8], in_byte};
								OFF_X_HI: x_d = {in_byte, x_q[7:0]};
								OFF_Y_LO: y_d = {y_q[15:8], in_byte};
								OFF_Y_HI: y_d = {in_byte, y_q[7:0]};
								OFF_Z_LO: zlo_d = in_byte;
								default: ;
							endcase
							if (off_q >= ACCEL_LAST) begin
								samp_d = samp_q + COUNT_BITS'(1);
								evt.valid = 1'b1;
								evt.kind = shtp_pkg::EVT_SAMPLE;
								evt.data.accuracy = status_q;
								evt.data.accel_x = x_q;
								evt.data.accel_y = y_q;
								evt.data.accel_z = {in_byte, zlo_q};
								rec_d = shtp_pkg::REC_ID;
								off_d = '0;
							end else begin
								off_d = off_q + 4'd1;
							end
						end
						shtp_pkg::REC_TIMEBASE: begin
							if (off_q >= TB_LAST) begin
								rec_d = shtp_pkg::REC_ID;
								off_d = '0;
							end else begin
								off_d = off_q + 4'd1;
							end
						end
						default: ;
					endcase
					if (rem_q <= 15'd1) begin
						rem_d = '0;
						hdr_d = shtp_pkg::HDR_IDLE;
					end else begin
						rem_d = rem_q - 15'd1;
					end
				end
				default: ;
			endcase
		end
		evt.data.sample_total = samp_ext[shtp_pkg::TOTAL_W-1:0];
		evt.data.read_error_total = rderr_ext[shtp_pkg::TOTAL_W-1:0];
		evt.data.parse_error_total = perr_ext[shtp_pkg::TOTAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= shtp_pkg::HDR_IDLE;
			rec_q <= shtp_pkg::REC_ID;
			off_q <= '0;
			len_lo_q <= '0;
			chan_q <= '0;
			rem_q <= '0;
			status_q <= '0;
			x_q <= '0;
			y_q <= '0;
			zlo_q <= '0;
			samp_q <= '0;
			rderr_q <= '0;
			perr_q <= '0;
		end else if (step) begin
			hdr_q <= hdr_d;
			rec_q <= rec_d;
			off_q <= off_d;
			len_lo_q <= len_lo_d;
			chan_q <= chan_d;
			rem_q <= rem_d;
			status_q <= status_d;
			x_q <= x_d;
			y_q <= y_d;
			zlo_q <= zlo_d;
			samp_q <= samp_d;
			rderr_q <= rderr_d;
			perr_q <= perr_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/shtp_accel_report_extractor_core.sv -----
// Channel   Direction  Carries
// s_t*      in         one received header or payload byte per beat
// m_t*      out        one event per beat: sample, bad length or truncated report
// APB       in/out     max_packet_len at 0x0, report_channel at 0x4
//
// A byte is registered on acceptance and parsed from that register; its event
// reaches m_tvalid through the output register. The block sustains one beat
// per cycle unless stalled. The input stage stalls only while it holds a byte
// that produces an event and the output register is full and not being taken.
// Reset clears the parser state, the counters and both stage valid flags.
`default_nettype none
`include "assert_macros.svh"
module shtp_accel_report_extractor_core #(
	parameter int COUNT_BITS = shtp_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata,  // [7:0] data_byte
	input wire logic s_tuser,        // [0] packet_start
	output logic m_tvalid,
	input wire logic m_tready,
	// [1:0] accuracy, [17:2] accel_x, [33:18] accel_y, [49:34] accel_z,
	// [81:50] sample_total, [113:82] read_error_total,
	// [145:114] parse_error_total, [151:146] zero
	output logic [151:0] m_tdata,
	output logic [1:0] m_tuser,      // [1:0] event_kind
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	shtp_pkg::cfg_t cfg;
	shtp_pkg::evt_t evt;
	logic in_valid_s1;
	logic [7:0] in_byte_s1;
	logic in_start_s1;
	logic out_valid_s2;
	shtp_pkg::evt_kind_t out_kind_s2;
	shtp_pkg::evt_data_t out_data_s2;
	logic advance;

	shtp_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	shtp_parse #(
		.COUNT_BITS(COUNT_BITS)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.in_byte(in_byte_s1),
		.in_start(in_start_s1),
		.cfg(cfg),
		.evt(evt)
	);

	assign advance = in_valid_s1 && (!out_valid_s2 || m_tready || !evt.valid);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
			in_start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && evt.valid) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && evt.valid) begin
			out_kind_s2 <= evt.kind;
			out_data_s2 <= evt.data;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tuser = out_kind_s2;
	assign m_tdata = {6'b0, out_data_s2};

	`SHTP_ASSERT_SAME(a_stall_only_when_full, !s_tready, in_valid_s1 && out_valid_s2 && !m_tready, "input stalled while the output register could take the event")
	`SHTP_ASSERT_NEXT(a_held_byte_kept, in_valid_s1 && !advance, in_valid_s1 && $stable(in_byte_s1) && $stable(in_start_s1), "a held byte was lost or changed")
	`SHTP_ASSERT_SAME(a_error_has_no_sample, m_tvalid && (m_tuser == shtp_pkg::EVT_READ_ERR || m_tuser == shtp_pkg::EVT_PARSE_ERR), m_tdata[49:0] == 50'd0, "error event carries sample data")

endmodule
`default_nettype wire

// ----- tb/sv/shtp_event_monitor.sv -----
`timescale 1ns / 1ps
module shtp_event_monitor
	import shtp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [7:0] s_tdata,  // [7:0] data_byte
	input logic s_tuser,        // [0] packet_start
	input logic m_tvalid,
	input logic m_tready,
	// [1:0] accuracy, [17:2] accel_x, [33:18] accel_y, [49:34] accel_z,
	// [81:50] sample_total, [113:82] read_error_total,
	// [145:114] parse_error_total, [151:146] zero
	input logic [151:0] m_tdata,
	input logic [1:0] m_tuser,  // [1:0] event_kind
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int mismatches,
	output int outstanding
);

	typedef struct {
		evt_kind_t kind;
		logic [1:0] accuracy;
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] az;
		logic [31:0] samples;
		logic [31:0] read_errs;
		logic [31:0] parse_errs;
	} sensor_event_t;

	sensor_event_t awaited_events[$];

	logic [LEN_W-1:0] max_len;
	logic [7:0] report_chan;

	hdr_state_t hdr_pos;
	rec_state_t rec;
	logic [7:0] len_lo;
	logic [7:0] pkt_chan;
	logic [LEN_W-1:0] remaining;
	logic [3:0] rec_off;
	logic [1:0] status;
	logic [15:0] x_acc;
	logic [15:0] y_acc;
	logic [7:0] z_lo;
	logic [31:0] sample_count;
	logic [31:0] read_err_count;
	logic [31:0] parse_err_count;

	task automatic note_event(input evt_kind_t kind, input logic [1:0] acc,
			input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az);
		sensor_event_t e;
		e.kind = kind;
		e.accuracy = acc;
		e.ax = ax;
		e.ay = ay;
		e.az = az;
		e.samples = sample_count;
		e.read_errs = read_err_count;
		e.parse_errs = parse_err_count;
		awaited_events.push_back(e);
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic start);
		logic [15:0] raw;
		logic [LEN_W-1:0] total;
		logic [LEN_W-1:0] need;
		logic [LEN_W-1:0] rem;
		if (start) begin
			len_lo = b;
			rec = REC_ID;
			rec_off = 4'd0;
			remaining = '0;
			hdr_pos = HDR_LEN_HI;
		end else begin
			case (hdr_pos)
				HDR_LEN_HI: begin
					raw = {b, len_lo};
					total = raw[LEN_W-1:0];
					if (raw == 16'h0000 || raw == NO_PACKET) begin
						hdr_pos = HDR_IDLE;
					end else if (total < HDR_LEN || total > max_len) begin
						read_err_count = read_err_count + 1;
						note_event(EVT_READ_ERR, 2'd0, 16'd0, 16'd0, 16'd0);
						hdr_pos = HDR_IDLE;
					end else begin
						remaining = total - HDR_LEN;
						hdr_pos = HDR_CHAN;
					end
				end
				HDR_CHAN: begin
					pkt_chan = b;
					hdr_pos = HDR_SEQ;
				end
				HDR_SEQ: begin
					rec = (pkt_chan == report_chan) ? REC_ID : REC_DISCARD;
					rec_off = 4'd0;
					hdr_pos = (remaining == 0) ? HDR_IDLE : HDR_PAYLOAD;
				end
				HDR_PAYLOAD: begin
					rem = remaining;
					case (rec)
						REC_ID: begin
							if (b == ID_ACCEL || b == ID_TIMEBASE) begin
								need = (b == ID_ACCEL) ? LEN_ACCEL : LEN_TIMEBASE;
								if (rem < need) begin
									parse_err_count = parse_err_count + 1;
									note_event(EVT_PARSE_ERR, 2'd0, 16'd0, 16'd0, 16'd0);
									rec = REC_DISCARD;
								end else begin
									rec = (b == ID_ACCEL) ? REC_ACCEL : REC_TIMEBASE;
									rec_off = 4'd1;
								end
							end
						end
						REC_ACCEL: begin
							case (rec_off)
								4'd2: status = b[1:0];
								4'd4: x_acc[7:0] = b;
								4'd5: x_acc[15:8] = b;
								4'd6: y_acc[7:0] = b;
								4'd7: y_acc[15:8] = b;
								4'd8: z_lo = b;
								default: ;
							endcase
							if (rec_off >= LEN_ACCEL - 1) begin
								sample_count = sample_count + 1;
								note_event(EVT_SAMPLE, status, x_acc, y_acc, {b, z_lo});
								rec = REC_ID;
								rec_off = 4'd0;
							end else begin
								rec_off = rec_off + 4'd1;
							end
						end
						REC_TIMEBASE: begin
							if (rec_off >= LEN_TIMEBASE - 1) begin
								rec = REC_ID;
								rec_off = 4'd0;
							end else begin
								rec_off = rec_off + 4'd1;
							end
						end
						default: ;
					endcase
					if (rem <= 1) begin
						remaining = '0;
						hdr_pos = HDR_IDLE;
					end else begin
						remaining = rem - 1'b1;
					end
				end
				default: ;
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic compare_event();
		sensor_event_t e;
		if (awaited_events.size() == 0) begin
			$error("event_kind: expected no beat, actual 0x%0h", m_tuser);
			mismatches++;
		end else begin
			e = awaited_events.pop_front();
			check_field("event_kind", e.kind, m_tuser);
			check_field("accuracy", e.accuracy, m_tdata[1:0]);
			check_field("accel_x", e.ax, m_tdata[17:2]);
			check_field("accel_y", e.ay, m_tdata[33:18]);
			check_field("accel_z", e.az, m_tdata[49:34]);
			check_field("sample_total", e.samples, m_tdata[81:50]);
			check_field("read_error_total", e.read_errs, m_tdata[113:82]);
			check_field("parse_error_total", e.parse_errs, m_tdata[145:114]);
			check_field("padding", 32'd0, m_tdata[151:146]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len = MAX_LEN_RST;
			report_chan = REPORT_CHAN_RST;
			hdr_pos = HDR_IDLE;
			rec = REC_ID;
			len_lo = '0;
			pkt_chan = '0;
			remaining = '0;
			rec_off = '0;
			status = '0;
			x_acc = '0;
			y_acc = '0;
			z_lo = '0;
			sample_count = '0;
			read_err_count = '0;
			parse_err_count = '0;
			awaited_events.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_event();
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_MAX_LEN: max_len = pwdata[LEN_W-1:0];
					REG_REPORT_CHAN: report_chan = pwdata[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tuser);
			outstanding <= awaited_events.size();
		end
	end

endmodule

// ----- tb/sv/shtp_accel_report_extractor_core_test.sv -----
`timescale 1ns / 1ps
module shtp_accel_report_extractor_core_test;
	import shtp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [7:0] s_tdata = 8'd0;
	logic s_tuser = 1'b0;
	logic m_tready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;

	logic s_tready;
	logic m_tvalid;
	logic [151:0] m_tdata;
	logic [1:0] m_tuser;
	logic [31:0] prdata;
	logic pready;

	int mismatches;
	int outstanding;

	logic steady = 1'b0;
	int sent = 0;
	int cur_max_len;
	logic [7:0] cur_chan;
	logic [7:0] frame[$];

	always #6 clk = ~clk;

	shtp_accel_report_extractor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	shtp_event_monitor monitor (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 15);
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic start);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 10)
			gap = $urandom_range(1, 2);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic send_frame(input logic lead_start);
		foreach (frame[i])
			send_byte(frame[i], lead_start && i == 0);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] max_word, input logic [31:0] chan_word);
		settle();
		reg_write({REG_MAX_LEN, 2'b00}, max_word);
		reg_write({REG_REPORT_CHAN, 2'b00}, chan_word);
		cur_max_len = max_word[LEN_W-1:0];
		cur_chan = chan_word[7:0];
	endtask

	function automatic logic [15:0] pick_axis_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return $urandom_range(16'hFFFF);
		endcase
	endfunction

	task automatic make_report_frame(input logic [7:0] chan, input bit cut);
		int budget;
		int len;
		int last_len;
		int k;
		logic [7:0] b;
		logic [15:0] v;
		logic [LEN_W-1:0] total;
		budget = cur_max_len - 4;
		if (budget > 40)
			budget = 40;
		frame.delete();
		repeat (4) frame.push_back(8'h00);
		last_len = 0;
		repeat ($urandom_range(1, 4)) begin
			k = $urandom_range(9);
			len = (k < 6) ? 10 : (k < 8) ? 5 : 1;
			if (frame.size() - 4 + len > budget)
				break;
			last_len = len;
			if (len == 10) begin
				frame.push_back(ID_ACCEL);
				repeat (3) frame.push_back($urandom_range(255));
				repeat (3) begin
					v = pick_axis_value();
					frame.push_back(v[7:0]);
					frame.push_back(v[15:8]);
				end
			end else if (len == 5) begin
				frame.push_back(ID_TIMEBASE);
				repeat (4) frame.push_back($urandom_range(255));
			end else begin
				b = $urandom_range(255);
				if (b == ID_ACCEL || b == ID_TIMEBASE)
					b = 8'h00;
				frame.push_back(b);
			end
		end
		if (cut && last_len > 1) begin
			k = $urandom_range(1, last_len - 1);
			repeat (k) void'(frame.pop_back());
		end
		total = frame.size();
		frame[0] = total[7:0];
		frame[1] = {1'b0, total[14:8]} | ($urandom_range(1) ? 8'h80 : 8'h00);
		frame[2] = chan;
		frame[3] = $urandom_range(255);
	endtask

	task automatic make_bad_length_frame();
		int t;
		logic [15:0] raw;
		if (cur_max_len < 32767 && $urandom_range(1)) begin
			t = cur_max_len + $urandom_range(1, 60);
			if (t > 32767)
				t = 32767;
		end else begin
			t = $urandom_range(3);
		end
		raw = t;
		raw[15] = $urandom_range(1);
		if ($urandom_range(4) == 0)
			raw = $urandom_range(1) ? NO_PACKET : 16'h0000;
		frame = {raw[7:0], raw[15:8]};
		repeat ($urandom_range(2)) frame.push_back($urandom_range(255));
	endtask

	task automatic random_traffic(input int count);
		int goal;
		int r;
		goal = sent + count;
		while (sent < goal) begin
			r = $urandom_range(99);
			if (r < 65) begin
				make_report_frame(cur_chan, $urandom_range(4) == 0);
				send_frame(1'b1);
			end else if (r < 75) begin
				make_report_frame(cur_chan + $urandom_range(1, 255), 1'b0);
				send_frame(1'b1);
			end else if (r < 85) begin
				make_bad_length_frame();
				send_frame(1'b1);
			end else if (r < 92) begin
				make_report_frame(cur_chan, 1'b0);
				if (frame.size() > 1)
					repeat (frame.size() - $urandom_range(1, frame.size() - 1))
						void'(frame.pop_back());
				send_frame(1'b1);
			end else begin
				frame.delete();
				repeat ($urandom_range(1, 6)) frame.push_back($urandom_range(255));
				send_frame($urandom_range(3) == 0);
			end
			if ($urandom_range(149) == 0)
				settle();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur_max_len = MAX_LEN_RST;
		cur_chan = REPORT_CHAN_RST;

		send_byte(8'h55, 1'b0);
		frame = {8'h00, 8'h00};
		send_frame(1'b1);
		frame = {8'hFF, 8'hFF};
		send_frame(1'b1);
		frame = {8'h03, 8'h80, 8'hAA};
		send_frame(1'b1);
		frame = {8'h01, 8'h02};
		send_frame(1'b1);
		frame = {8'h04, 8'h00, 8'h05, 8'h77};
		send_frame(1'b1);
		frame = {8'h17, 8'h00, 8'h03, 8'h00, 8'hFB, 8'h10, 8'h20, 8'h30, 8'h40,
			8'h01, 8'h5A, 8'hFF, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
			8'h00, 8'h01, 8'h33, 8'h44};
		send_frame(1'b1);
		frame = {8'h0E, 8'h80, 8'h03, 8'h01, 8'h01, 8'h00, 8'hFC, 8'h00,
			8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h00};
		send_frame(1'b1);
		frame = {8'h0E, 8'h00, 8'h03, 8'h02, 8'h01, 8'h11, 8'h22};
		send_frame(1'b1);
		frame = {8'h06, 8'h00, 8'h07, 8'h00, 8'h01, 8'hFB};
		send_frame(1'b1);
		frame = {8'h07, 8'h00, 8'h03, 8'h00, 8'h00, 8'hFB, 8'h01};
		send_frame(1'b1);

		random_traffic(300);
		set_config(($urandom & 32'hFFFF_8000) | 32'd4, $urandom & 32'hFFFF_FF00);
		random_traffic(100);
		set_config(32'd32767, 32'd255);
		steady = 1'b1;
		random_traffic(200);
		steady = 1'b0;
		random_traffic(150);
		set_config($urandom_range(14, 300), $urandom_range(255));
		random_traffic(400);

		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/shtp_pkg.sv
rtl/shtp_regs.sv
rtl/shtp_parse.sv
rtl/shtp_accel_report_extractor_core.sv
tb/sv/shtp_event_monitor.sv
tb/sv/shtp_accel_report_extractor_core_test.sv
